[design/rgbw_pkg.sv]
`default_nettype none

package rgbw_pkg;

    // panel geometry
    localparam int unsigned SECTIONS = 36;
    localparam int unsigned ROWS     = 22;
    localparam int unsigned COLUMNS  = 32;

    // field widths
    localparam int VAL_W  = 16;
    localparam int ADDR_W = 15;
    localparam int SECT_W = 6;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 5;
    localparam int GAIN_W = 8;
    localparam int WSUM_W = 23;

    // flat buffer strides, address wraps at 2^15
    localparam logic [ADDR_W-1:0] SECT_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(SECTIONS * COLUMNS);
    localparam logic [ROW_W:0]    MID_ROW     = (ROW_W + 1)'(ROWS / 2);

    // luma weights in percent
    localparam logic [6:0] W_RED   = 7'd30;
    localparam logic [6:0] W_GREEN = 7'd55;
    localparam logic [6:0] W_BLUE  = 7'd15;

    // divide by 100 as multiply by ceil(2^30/100), exact for sums below 2^23
    localparam int          LUMA_DIV   = 100;
    localparam int          LUMA_SHIFT = 30;
    localparam int          RECIP_W    = 24;
    localparam logic [RECIP_W-1:0] LUMA_RECIP =
        RECIP_W'(((64'd1 << LUMA_SHIFT) + 64'(LUMA_DIV) - 64'd1) / 64'(LUMA_DIV));

    // gain scaling
    localparam int WHITE_SHIFT = 3;
    localparam int OUT_SHIFT   = 4;

    typedef enum logic [2:0] {
        CH_RED     = 3'd0,
        CH_GREEN   = 3'd1,
        CH_BLUE    = 3'd2,
        CH_WHITE   = 3'd3,
        CH_OUTSIDE = 3'd4
    } chan_t;

    typedef enum logic [1:0] {
        REG_WHITE_ENABLE   = 2'd0,
        REG_OUTSIDE_ENABLE = 2'd1,
        REG_WHITE_GAIN     = 2'd2,
        REG_OUTSIDE_GAIN   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic              white_enable;
        logic              outside_enable;
        logic [GAIN_W-1:0] white_gain;
        logic [GAIN_W-1:0] outside_gain;
    } cfg_t;

    // one unit of work from front to back
    typedef struct packed {
        logic              is_white;
        logic [VAL_W-1:0]  red;
        logic [VAL_W-1:0]  green;
        logic [VAL_W-1:0]  blue;
        logic [VAL_W-1:0]  min_rgb;
        logic [WSUM_W-1:0] wsum;
        logic [ADDR_W-1:0] addr_red;
        logic [ADDR_W-1:0] addr_green;
        logic [ADDR_W-1:0] addr_blue;
        logic [ADDR_W-1:0] addr_last;
    } job_t;

endpackage

`default_nettype wire

[design/rgbw_front.sv]
`default_nettype none

module rgbw_front
    import rgbw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic [VAL_W-1:0]  sample_value,
    input  logic [SECT_W-1:0] section_index,
    input  logic [ROW_W-1:0]  row_index,
    input  logic [COL_W-1:0]  column_index,
    output logic              job_push,
    output job_t              job
);

    typedef enum logic [4:0] {
        PH_RED     = 5'b00001,
        PH_GREEN   = 5'b00010,
        PH_BLUE    = 5'b00100,
        PH_WHITE   = 5'b01000,
        PH_OUTSIDE = 5'b10000
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    phase_t            phase_now;
    logic              restart;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  red_reg;
    logic [VAL_W-1:0]  green_reg;
    logic [VAL_W-1:0]  blue_reg;
    logic [VAL_W-1:0]  min_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [ADDR_W-1:0] hist0_reg;
    logic [ADDR_W-1:0] hist1_reg;
    logic [ADDR_W-1:0] hist2_reg;
    logic [VAL_W-1:0]  min_rg;
    logic [VAL_W-1:0]  min_rgb;
    logic [WSUM_W-1:0] wsum;

    // flat buffer address of this sample
    assign addr = ADDR_W'(section_index) * SECT_STRIDE
                + ADDR_W'(row_index) * ROW_STRIDE
                + ADDR_W'(column_index);

    // phase restarts at section start and at column 0 of the middle row
    assign restart   = (column_index == '0)
                     && ((row_index == '0) || ({1'b0, row_index} == MID_ROW));
    assign phase_now = restart ? PH_RED : phase_reg;

    always_comb
    begin
        unique case (phase_now)
            PH_RED:     phase_next = PH_GREEN;
            PH_GREEN:   phase_next = PH_BLUE;
            PH_BLUE:    phase_next = PH_WHITE;
            PH_WHITE:   phase_next = PH_OUTSIDE;
            PH_OUTSIDE: phase_next = PH_RED;
            default:    phase_next = PH_RED;
        endcase
    end

    // minimum and weighted sum formed as blue arrives
    assign min_rg  = (red_reg <= green_reg) ? red_reg : green_reg;
    assign min_rgb = (sample_value <= min_rg) ? sample_value : min_rg;
    assign wsum    = WSUM_W'(red_reg) * WSUM_W'(W_RED)
                   + WSUM_W'(green_reg) * WSUM_W'(W_GREEN)
                   + WSUM_W'(sample_value) * WSUM_W'(W_BLUE);

    // job to the back end at the white and outside phases
    assign job_push       = in_accept && ((phase_now == PH_WHITE) || (phase_now == PH_OUTSIDE));
    assign job.is_white   = (phase_now == PH_WHITE);
    assign job.red        = red_reg;
    assign job.green      = green_reg;
    assign job.blue       = blue_reg;
    assign job.min_rgb    = min_reg;
    assign job.wsum       = wsum_reg;
    assign job.addr_red   = hist0_reg;
    assign job.addr_green = hist1_reg;
    assign job.addr_blue  = hist2_reg;
    assign job.addr_last  = addr;

    // phase counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RED;
        end
        else if (in_accept)
        begin
            phase_reg <= phase_next;
        end
    end

    // held colors and address history; a restart forces the red phase, so
    // values held from before a restart are always rewritten before use
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hist0_reg <= hist1_reg;
            hist1_reg <= hist2_reg;
            hist2_reg <= addr;
            if (phase_now == PH_RED)
            begin
                red_reg <= sample_value;
            end
            if (phase_now == PH_GREEN)
            begin
                green_reg <= sample_value;
            end
            if (phase_now == PH_BLUE)
            begin
                blue_reg <= sample_value;
                min_reg  <= min_rgb;
                wsum_reg <= wsum;
            end
        end
    end

endmodule

`default_nettype wire

[design/rgbw_job_queue.sv]
`default_nettype none

module rgbw_job_queue
    import rgbw_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output job_t rd_data,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("job queue read while empty");

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> !empty)
        else $error("job queue empty after a lone write");

endmodule

`default_nettype wire

[design/rgbw_back.sv]
`default_nettype none

module rgbw_back
    import rgbw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              job_valid,
    input  job_t              job,
    output logic              job_pop,
    input  logic              pop,
    output logic              empty,
    output logic [VAL_W-1:0]  out_value,
    output logic [ADDR_W-1:0] out_address,
    output logic [2:0]        channel,
    output logic              last
);

    localparam int WPROD_W = VAL_W + GAIN_W;
    localparam int LPROD_W = WSUM_W + RECIP_W;
    localparam int WSHF_W  = WPROD_W - WHITE_SHIFT;

    // stage a: operands
    logic               a_valid_reg;
    job_t               a_job_reg;
    logic               a_ready;
    logic [WPROD_W-1:0] white_prod;
    logic [LPROD_W-1:0] luma_prod;

    // stage b: products
    logic               b_valid_reg;
    job_t               b_job_reg;
    logic [WPROD_W-1:0] b_wprod_reg;
    logic [VAL_W-1:0]   b_luma_reg;
    logic               b_ready;
    logic [WSHF_W-1:0]  white_shf;
    logic [VAL_W-1:0]   white_val;
    logic [WPROD_W-1:0] out_prod;
    logic [VAL_W-1:0]   outside_val;
    logic [VAL_W-1:0]   held_luma_reg;

    // stage c: result sequencer
    logic               c_valid_reg;
    logic [1:0]         c_rem_reg;
    logic [VAL_W-1:0]   c_val_reg  [4];
    logic [ADDR_W-1:0]  c_addr_reg [4];
    chan_t              c_chan_reg [4];
    logic               c_last;
    logic               c_ready;
    logic               c_load;
    logic               c_shift;

    assign a_ready = !a_valid_reg || b_ready;
    assign job_pop = job_valid && a_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign c_last  = (c_rem_reg == '0);
    assign c_ready = !c_valid_reg || (pop && c_last);
    assign c_load  = b_valid_reg && c_ready;
    assign c_shift = pop && c_valid_reg && !c_last;

    // white product and luma by reciprocal multiply
    assign white_prod = WPROD_W'(a_job_reg.min_rgb) * WPROD_W'(cfg.white_gain);
    assign luma_prod  = LPROD_W'(a_job_reg.wsum) * LPROD_W'(LUMA_RECIP);

    // white saturation and outside scaling
    assign white_shf = b_wprod_reg[WPROD_W-1:WHITE_SHIFT];
    always_comb
    begin
        if (!cfg.white_enable)
        begin
            white_val = '0;
        end
        else if (white_shf > WSHF_W'({VAL_W{1'b1}}))
        begin
            white_val = {VAL_W{1'b1}};
        end
        else
        begin
            white_val = white_shf[VAL_W-1:0];
        end
    end

    assign out_prod    = WPROD_W'(held_luma_reg) * WPROD_W'(cfg.outside_gain);
    assign outside_val = cfg.outside_enable ? out_prod[OUT_SHIFT +: VAL_W] : '0;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            c_rem_reg     <= '0;
            held_luma_reg <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= job_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (c_load)
            begin
                c_rem_reg <= b_job_reg.is_white ? 2'd3 : 2'd0;
            end
            else if (c_shift)
            begin
                c_rem_reg <= c_rem_reg - 1'b1;
            end
            // luma of the latest white group feeds the outside pixel after it
            if (c_load && b_job_reg.is_white)
            begin
                held_luma_reg <= b_luma_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            a_job_reg <= job;
        end
        if (a_valid_reg && b_ready)
        begin
            b_job_reg   <= a_job_reg;
            b_wprod_reg <= white_prod;
            b_luma_reg  <= luma_prod[LUMA_SHIFT +: VAL_W];
        end
        if (c_load)
        begin
            if (b_job_reg.is_white)
            begin
                c_val_reg[0]  <= b_job_reg.red - white_val;
                c_val_reg[1]  <= b_job_reg.green - white_val;
                c_val_reg[2]  <= b_job_reg.blue - white_val;
                c_val_reg[3]  <= white_val;
                c_addr_reg[0] <= b_job_reg.addr_red;
                c_addr_reg[1] <= b_job_reg.addr_green;
                c_addr_reg[2] <= b_job_reg.addr_blue;
                c_addr_reg[3] <= b_job_reg.addr_last;
                c_chan_reg[0] <= CH_RED;
                c_chan_reg[1] <= CH_GREEN;
                c_chan_reg[2] <= CH_BLUE;
                c_chan_reg[3] <= CH_WHITE;
            end
            else
            begin
                c_val_reg[0]  <= outside_val;
                c_addr_reg[0] <= b_job_reg.addr_last;
                c_chan_reg[0] <= CH_OUTSIDE;
            end
        end
        else if (c_shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_val_reg[i]  <= c_val_reg[i+1];
                c_addr_reg[i] <= c_addr_reg[i+1];
                c_chan_reg[i] <= c_chan_reg[i+1];
            end
        end
    end

    // result ports
    assign empty       = !c_valid_reg;
    assign out_value   = c_val_reg[0];
    assign out_address = c_addr_reg[0];
    assign channel     = c_chan_reg[0];
    assign last        = c_last;

    a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=> !empty)
        else $error("result group ended before its last transfer");

    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (channel == CH_WHITE || channel == CH_OUTSIDE))
        else $error("last result not white or outside");

    a_stage_b_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !c_ready) |=> b_valid_reg)
        else $error("stalled product stage dropped its job");

endmodule

`default_nettype wire

[design/rgb_to_rgbw_led_stream_unit.sv]
`default_nettype none

// RGB to RGBW LED stream converter. Samples enter in scan order, one per
// cycle, and are labelled red, green, blue, white and outside in turns of
// five; the count restarts at each section start and at column 0 of the
// middle row. Red, green and blue samples give no result, the white sample
// gives four results (red, green and blue less the extracted white, then
// white) and the outside sample gives one scaled-luma result, each with its
// flat buffer address. An input is taken on any cycle the job queue has
// room; the first result of a white or outside sample passes the job queue
// and the operand, product and sequencer stages, then results follow one
// per cycle while pop is held, so a five-sample group gives five results
// and the stream sustains one sample per cycle, set by the output sequencer
// that emits one result a cycle. Addresses wrap at 2^15. Registers are to
// be written only while no results are outstanding, which is not enforced.
module rgb_to_rgbw_led_stream_unit
    import rgbw_pkg::*;
#(
    parameter int JOB_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    // sample input
    input  logic              push,
    output logic              full,
    input  logic [VAL_W-1:0]  sample_value,
    input  logic [SECT_W-1:0] section_index,
    input  logic [ROW_W-1:0]  row_index,
    input  logic [COL_W-1:0]  column_index,
    // results
    output logic              empty,
    input  logic              pop,
    output logic [VAL_W-1:0]  out_value,
    output logic [ADDR_W-1:0] out_address,
    output logic [2:0]        channel,
    output logic              last,
    // register writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [GAIN_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic in_accept;
    logic job_push;
    job_t job_in;
    logic job_pop;
    job_t job_out;
    logic job_empty;

    assign cfg_ready = 1'b1;
    assign in_accept = push && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.white_enable   <= 1'b1;
            cfg_reg.outside_enable <= 1'b1;
            cfg_reg.white_gain     <= 8'd8;
            cfg_reg.outside_gain   <= 8'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WHITE_ENABLE:   cfg_reg.white_enable   <= cfg_data[0];
                REG_OUTSIDE_ENABLE: cfg_reg.outside_enable <= cfg_data[0];
                REG_WHITE_GAIN:     cfg_reg.white_gain     <= cfg_data;
                REG_OUTSIDE_GAIN:   cfg_reg.outside_gain   <= cfg_data;
            endcase
        end
    end

    // phase tracking and job formation
    rgbw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (in_accept),
        .sample_value  (sample_value),
        .section_index (section_index),
        .row_index     (row_index),
        .column_index  (column_index),
        .job_push      (job_push),
        .job           (job_in)
    );

    // decoupling queue
    rgbw_job_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    // arithmetic and result sequencing
    rgbw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_valid   (!job_empty),
        .job         (job_out),
        .job_pop     (job_pop),
        .pop         (pop),
        .empty       (empty),
        .out_value   (out_value),
        .out_address (out_address),
        .channel     (channel),
        .last        (last)
    );

endmodule

`default_nettype wire

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbw_pkg::*;

    localparam int unsigned SETTLE_CYCLES     = 12;
    localparam int unsigned HOLD_OFF_CYCLES   = 300;
    localparam int unsigned NO_TRANSFER_LIMIT = 4000;
    localparam int unsigned RANDOM_SAMPLES    = 370;
    localparam int unsigned RETUNE_SPACING    = 90;

    typedef enum logic [2:0] {
        PH_RED     = 3'd0,
        PH_GREEN   = 3'd1,
        PH_BLUE    = 3'd2,
        PH_WHITE   = 3'd3,
        PH_OUTSIDE = 3'd4
    } scan_phase_t;

    typedef struct {
        logic [VAL_W-1:0]  value;
        logic [ADDR_W-1:0] addr;
        chan_t             chan;
        logic              last;
    } drive_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [VAL_W-1:0]  sample_value = '0;
    logic [SECT_W-1:0] section_index = '0;
    logic [ROW_W-1:0]  row_index = '0;
    logic [COL_W-1:0]  column_index = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [VAL_W-1:0]  out_value;
    logic [ADDR_W-1:0] out_address;
    logic [2:0]        channel;
    logic              last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [GAIN_W-1:0] cfg_data = '0;

    rgb_to_rgbw_led_stream_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sample_value  (sample_value),
        .section_index (section_index),
        .row_index     (row_index),
        .column_index  (column_index),
        .empty         (empty),
        .pop           (pop),
        .out_value     (out_value),
        .out_address   (out_address),
        .channel       (channel),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // white extraction state mirrored from the block
    cfg_t              led_cfg;
    scan_phase_t       scan_phase;
    logic [VAL_W-1:0]  hold_red;
    logic [VAL_W-1:0]  hold_green;
    logic [VAL_W-1:0]  hold_blue;
    logic [VAL_W-1:0]  hold_luma;
    logic [ADDR_W-1:0] addr_trail [3];

    drive_result_t expected_drive [$];

    int unsigned fail_count       = 0;
    int unsigned samples_sent     = 0;
    int unsigned results_checked  = 0;
    int unsigned settings_applied = 0;
    int unsigned send_burst_left  = 0;
    int unsigned recv_burst_left  = 0;
    bit          hold_off_req     = 1'b0;

    // wait draw with occasional stretches of back-to-back transfers
    function automatic int unsigned pick_wait(inout int unsigned burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [VAL_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return VAL_W'($urandom_range(0, 255));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return GAIN_W'(8);
            default: return GAIN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_drive(logic [VAL_W-1:0] value, logic [ADDR_W-1:0] addr,
                                        chan_t chan, logic is_last);
        drive_result_t res;
        res.value = value;
        res.addr  = addr;
        res.chan  = chan;
        res.last  = is_last;
        expected_drive.push_back(res);
    endfunction

    function automatic void reset_led_state();
        led_cfg.white_enable   = 1'b1;
        led_cfg.outside_enable = 1'b1;
        led_cfg.white_gain     = GAIN_W'(8);
        led_cfg.outside_gain   = GAIN_W'(3);
        scan_phase = PH_RED;
        hold_red   = '0;
        hold_green = '0;
        hold_blue  = '0;
        hold_luma  = '0;
        addr_trail[0] = '0;
        addr_trail[1] = '0;
        addr_trail[2] = '0;
    endfunction

    // expected drive values for one accepted sample
    function automatic void predict_led_results(logic [VAL_W-1:0] sample, logic [SECT_W-1:0] sect,
                                                logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        int unsigned       flat;
        int unsigned       wsum;
        int unsigned       mono;
        int unsigned       white;
        int unsigned       outside;
        logic [ADDR_W-1:0] addr;
        flat = int'(sect) * COLUMNS + int'(row) * SECTIONS * COLUMNS + int'(col);
        addr = ADDR_W'(flat);

        // section start clears everything, middle row only realigns the phase
        if (row == 0 && col == 0)
        begin
            scan_phase = PH_RED;
            hold_red   = '0;
            hold_green = '0;
            hold_blue  = '0;
            hold_luma  = '0;
            addr_trail[0] = '0;
            addr_trail[1] = '0;
            addr_trail[2] = '0;
        end
        else if (int'(row) == ROWS / 2 && col == 0)
        begin
            scan_phase = PH_RED;
        end

        case (scan_phase)
            PH_RED:   hold_red   = sample;
            PH_GREEN: hold_green = sample;
            PH_BLUE:  hold_blue  = sample;
            PH_WHITE:
            begin
                wsum = 32'(W_RED) * hold_red + 32'(W_GREEN) * hold_green
                       + 32'(W_BLUE) * hold_blue;
                hold_luma = VAL_W'(wsum / 100);
                white = 0;
                if (led_cfg.white_enable)
                begin
                    mono = hold_red;
                    if (hold_green < mono)
                        mono = hold_green;
                    if (hold_blue < mono)
                        mono = hold_blue;
                    white = (mono * led_cfg.white_gain) / 8;
                    if (white > 65535)
                        white = 65535;
                end
                queue_drive(hold_red - VAL_W'(white), addr_trail[0], CH_RED, 1'b0);
                queue_drive(hold_green - VAL_W'(white), addr_trail[1], CH_GREEN, 1'b0);
                queue_drive(hold_blue - VAL_W'(white), addr_trail[2], CH_BLUE, 1'b0);
                queue_drive(VAL_W'(white), addr, CH_WHITE, 1'b1);
            end
            default:
            begin
                outside = 0;
                if (led_cfg.outside_enable)
                    outside = (32'(hold_luma) * led_cfg.outside_gain) / 16;
                queue_drive(VAL_W'(outside), addr, CH_OUTSIDE, 1'b1);
            end
        endcase

        addr_trail[0] = addr_trail[1];
        addr_trail[1] = addr_trail[2];
        addr_trail[2] = addr;
        scan_phase = (scan_phase == PH_OUTSIDE) ? PH_RED : scan_phase_t'(scan_phase + 3'd1);
    endfunction

    // one sample transfer; push is left high so a following zero-wait item needs no toggle
    task automatic send_sample(input logic [VAL_W-1:0] value, input logic [SECT_W-1:0] sect,
                               input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        int unsigned gap;
        gap = pick_wait(send_burst_left);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        sample_value  <= value;
        section_index <= sect;
        row_index     <= row;
        column_index  <= col;
        do
            @(posedge clk);
        while (full);
        predict_led_results(value, sect, row, col);
        samples_sent++;
    endtask

    // drain all results, then let any result-free samples clear the pipeline
    task automatic wait_for_idle();
        push <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic we, input logic oe,
                                  input logic [GAIN_W-1:0] wg, input logic [GAIN_W-1:0] og);
        reg_index_t        idx;
        logic [GAIN_W-1:0] data;
        wait_for_idle();
        for (int i = 0; i < 4; i++)
        begin
            idx = reg_index_t'(i);
            case (idx)
                REG_WHITE_ENABLE:   data = GAIN_W'(we);
                REG_OUTSIDE_ENABLE: data = GAIN_W'(oe);
                REG_WHITE_GAIN:     data = wg;
                default:            data = og;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx)
                REG_WHITE_ENABLE:   led_cfg.white_enable   = data[0];
                REG_OUTSIDE_ENABLE: led_cfg.outside_enable = data[0];
                REG_WHITE_GAIN:     led_cfg.white_gain     = data;
                default:            led_cfg.outside_gain   = data;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // one full R, G, B, W, X group at the start of a section
    task automatic send_group(input logic [SECT_W-1:0] sect, input logic [VAL_W-1:0] r,
                              input logic [VAL_W-1:0] g, input logic [VAL_W-1:0] b);
        send_sample(r, sect, '0, COL_W'(0));
        send_sample(g, sect, '0, COL_W'(1));
        send_sample(b, sect, '0, COL_W'(2));
        send_sample(pick_sample(), sect, '0, COL_W'(3));
        send_sample(pick_sample(), sect, '0, COL_W'(4));
    endtask

    // walk the scan order from a given position
    task automatic scan_run(input int unsigned sect, input int unsigned row,
                            input int unsigned col, input int unsigned len);
        for (int unsigned n = 0; n < len; n++)
        begin
            send_sample(pick_sample(), SECT_W'(sect), ROW_W'(row), COL_W'(col));
            col++;
            if (col == COLUMNS)
            begin
                col = 0;
                row++;
                if (row == ROWS)
                begin
                    row  = 0;
                    sect = (sect + 1) % SECTIONS;
                end
            end
        end
    endtask

    // result transfers and checking
    initial
    begin
        drive_result_t exp_res;
        int unsigned   gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            gap = pick_wait(recv_burst_left);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            results_checked++;
            if (expected_drive.size() == 0)
            begin
                $error("result with none pending: out_value %0d out_address %0d channel %0d",
                       out_value, out_address, channel);
                fail_count++;
            end
            else
            begin
                exp_res = expected_drive.pop_front();
                if (out_value !== exp_res.value)
                begin
                    $error("out_value: expected %0d, got %0d", exp_res.value, out_value);
                    fail_count++;
                end
                if (out_address !== exp_res.addr)
                begin
                    $error("out_address: expected %0d, got %0d", exp_res.addr, out_address);
                    fail_count++;
                end
                if (channel !== exp_res.chan)
                begin
                    $error("channel: expected %0d, got %0d", exp_res.chan, channel);
                    fail_count++;
                end
                if (last !== exp_res.last)
                begin
                    $error("last: expected %0d, got %0d", exp_res.last, last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int unsigned idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= NO_TRANSFER_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // field extremes, restarts and address wrap at reset settings
    task automatic test_directed();
        // all channels at full scale
        send_group(SECT_W'(0), '1, '1, '1);
        // section start in the middle of a group
        send_sample(VAL_W'(100), SECT_W'(0), '0, COL_W'(5));
        send_sample(VAL_W'(50), SECT_W'(0), '0, COL_W'(6));
        send_sample(VAL_W'(200), SECT_W'(0), '0, COL_W'(7));
        send_group(SECT_W'(1), VAL_W'(4000), VAL_W'(9), VAL_W'(65000));
        // middle row column 0 realigns the phase
        send_sample(pick_sample(), SECT_W'(2), ROW_W'(ROWS / 2 - 1), COL_W'(COLUMNS - 2));
        send_sample(pick_sample(), SECT_W'(2), ROW_W'(ROWS / 2 - 1), COL_W'(COLUMNS - 1));
        scan_run(2, ROWS / 2, 0, 5);
        // indices past the panel, address wraps
        send_sample(VAL_W'(1), '1, '1, '1);
        send_sample(VAL_W'(2), '1, '1, '1);
        send_sample(VAL_W'(3), '1, '1, '1);
        send_sample('0, '1, '1, '1);
        send_sample('1, '1, '1, '1);
        wait_for_idle();
    endtask

    // gain and enable extremes
    task automatic test_settings_extremes();
        apply_settings(1'b1, 1'b1, '1, '1);
        send_group(SECT_W'(3), '1, '1, '1);
        send_group(SECT_W'(4), VAL_W'(1000), VAL_W'(2000), VAL_W'(3000));
        apply_settings(1'b0, 1'b0, '0, '0);
        send_group(SECT_W'(5), VAL_W'(777), '1, VAL_W'(12345));
        apply_settings(1'b1, 1'b1, '0, '0);
        send_group(SECT_W'(6), '1, VAL_W'(30000), '1);
        apply_settings(1'b0, 1'b1, '1, GAIN_W'(16));
        send_group(SECT_W'(SECTIONS - 1), '0, '0, '0);
        apply_settings(1'b1, 1'b0, GAIN_W'(8), GAIN_W'(3));
        send_group(SECT_W'(7), VAL_W'(40000), VAL_W'(50000), VAL_W'(60000));
        wait_for_idle();
    endtask

    // receiver stalls long enough for the block to fill and stall its input
    task automatic test_output_stall();
        apply_settings(1'b1, 1'b1, GAIN_W'(8), GAIN_W'(3));
        hold_off_req = 1'b1;
        scan_run($urandom_range(0, SECTIONS - 1), 0, 0, 60);
        wait_for_idle();
    endtask

    // scan runs with random content, some broken runs and noise
    task automatic test_random_scan();
        int unsigned target;
        int unsigned next_retune;
        int unsigned len;
        target      = samples_sent + RANDOM_SAMPLES;
        next_retune = samples_sent + RETUNE_SPACING;
        while (samples_sent < target)
        begin
            len = $urandom_range(5, 40);
            case ($urandom_range(0, 9))
                0:
                begin
                    repeat ($urandom_range(1, 6))
                        send_sample(pick_sample(), SECT_W'($urandom), ROW_W'($urandom),
                                    COL_W'($urandom));
                end
                1, 2, 3, 4, 5: scan_run($urandom_range(0, SECTIONS - 1), 0, 0, len);
                6, 7: scan_run($urandom_range(0, SECTIONS - 1), ROWS / 2 - 1,
                               $urandom_range(COLUMNS - 8, COLUMNS - 1), len);
                8: scan_run($urandom_range(0, SECTIONS - 1), ROWS - 1,
                            $urandom_range(COLUMNS - 8, COLUMNS - 1), len);
                default: scan_run($urandom_range(0, SECTIONS - 1), $urandom_range(0, ROWS - 1),
                                  $urandom_range(0, COLUMNS - 1), len);
            endcase
            if (samples_sent >= next_retune)
            begin
                apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               pick_gain(), pick_gain());
                next_retune = samples_sent + RETUNE_SPACING;
            end
        end
        wait_for_idle();
    endtask

    // sequence of tests
    initial
    begin
        reset_led_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_settings_extremes();
        test_output_stall();
        test_random_scan();

        wait_for_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d samples, %0d results, %0d register settings", samples_sent,
                 results_checked, settings_applied);
        $display("with gain saturation, restarts, address wrap and a long output stall");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
